/* rtl/ric_pkg.sv */
package ric_pkg;

  localparam int unsigned OFFSET_W = 48;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned END_W    = 49;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CFG_IDX_W = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP    = 8'd1;

  // Values used when a register holds zero
  localparam logic [OFFSET_W-1:0] DEFAULT_WINDOW = 48'd536870912;
  localparam logic [OFFSET_W-1:0] DEFAULT_GAP    = 48'd8388608;

  typedef struct packed {
    logic [OFFSET_W-1:0] record_offset;
    logic [SIZE_W-1:0]   record_len;
    logic                final_record;
  } ric_record_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] interval_offset;
    logic [END_W-1:0]    interval_size;
    logic [COUNT_W-1:0]  interval_tasks;
    logic [COUNT_W-1:0]  first_index;
    logic                last_of_run;
  } ric_interval_t;

  // Up to two intervals enter the result queue per request
  typedef struct packed {
    logic valid_a;
    logic valid_b;
  } ric_push_t;

endpackage

/* rtl/ric_out_queue.sv */
module ric_out_queue import ric_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  ric_push_t     push,
  input  ric_interval_t push_a,
  input  ric_interval_t push_b,
  output logic          room_for_two,
  output logic          interval_valid,
  input  logic          interval_ready,
  output ric_interval_t interval
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);

  ric_interval_t    entries [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] tail_1;
  logic [PTR_W-1:0] tail_2;
  logic [PTR_W-1:0] head_1;
  logic             pop;
  logic [1:0]       push_n;
  logic [CNT_W-1:0] count_next;
  logic [PTR_W-1:0] tail_next;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  assign tail_1 = ptr_inc(tail);
  assign tail_2 = ptr_inc(tail_1);
  assign head_1 = ptr_inc(head);

  assign pop    = interval_valid && interval_ready;
  assign push_n = {1'b0, push.valid_a} + {1'b0, push.valid_b};

  always_comb begin
    count_next = count + CNT_W'(push_n) - CNT_W'(pop);
    case (push_n)
      2'd1:    tail_next = tail_1;
      2'd2:    tail_next = tail_2;
      default: tail_next = tail;
    endcase
  end

  // Pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail_next;
      count <= count_next;
      if (pop) begin
        head <= head_1;
      end
    end
  end

  // Entry storage; a lone second result takes the first free slot
  always_ff @(posedge clk) begin
    if (push.valid_a) begin
      entries[tail] <= push_a;
      if (push.valid_b) begin
        entries[tail_1] <= push_b;
      end
    end else if (push.valid_b) begin
      entries[tail] <= push_b;
    end
  end

  assign interval_valid = (count != '0);
  assign interval       = entries[head];
  assign room_for_two   = (count <= ROOM_LIMIT);

endmodule

/* rtl/read_interval_coalescer.sv */
// Read interval coalescer.
// Record requests (offset, size, final flag) arrive on record_valid/record_ready
// in ascending offset order. Each is merged into the open read interval or
// closes it; closed intervals leave on interval_valid/interval_ready.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high. Index 0 is the span limit, index 1 is max_gap, zero selects
// the 512 MiB / 8 MiB defaults, other indexes are ignored.
// Throughput: one record per cycle while record_ready is high. A record
// yields zero, one or two intervals; the output side drains one interval per
// cycle while interval_ready is high, so a record that both closes an
// interval and ends the plan fills two queue slots. A closed interval is
// registered in the result queue when the record that closes it is accepted.
// The result queue holds OUT_DEPTH intervals; record_ready drops when fewer
// than two slots are free, so a stalled receiver back-pressures the input
// without losing intervals.
// Reset (rst, synchronous) empties the queue, closes any open interval, zeros
// the task counters and both registers.
module read_interval_coalescer import ric_pkg::*; #(
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 record_valid,
  output logic                 record_ready,
  input  ric_record_t          record,
  output logic                 interval_valid,
  input  logic                 interval_ready,
  output ric_interval_t        interval,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OFFSET_W-1:0]  cfg_data
);

  logic [OFFSET_W-1:0] span_limit;
  logic [OFFSET_W-1:0] max_gap;

  logic                interval_open;
  logic [OFFSET_W-1:0] open_start;
  logic [OFFSET_W-1:0] latest_start;
  logic [END_W-1:0]    furthest_end;
  logic [COUNT_W-1:0]  open_count;
  logic [COUNT_W-1:0]  records_seen;

  logic                interval_open_next;
  logic [OFFSET_W-1:0] open_start_next;
  logic [OFFSET_W-1:0] latest_start_next;
  logic [END_W-1:0]    furthest_end_next;
  logic [COUNT_W-1:0]  open_count_next;
  logic [COUNT_W-1:0]  records_seen_next;

  logic                accept;
  logic                room_for_two;
  logic [END_W-1:0]    rec_start;
  logic [END_W-1:0]    rec_end;
  logic [OFFSET_W-1:0] win;
  logic [OFFSET_W-1:0] gap;
  logic [END_W-1:0]    gap_limit;
  logic [END_W-1:0]    span;
  logic                gap_fail;
  logic                win_fail;
  logic                joins;
  logic [COUNT_W-1:0]  seen_inc;
  ric_push_t           push;
  ric_interval_t       result_a;
  ric_interval_t       result_b;

  assign cfg_ready    = 1'b1;
  assign record_ready = room_for_two;
  assign accept       = record_valid && record_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      span_limit <= '0;
      max_gap    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SPAN_LIMIT: span_limit <= cfg_data;
        REG_MAX_GAP:    max_gap    <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Join tests against the open interval
  always_comb begin
    win       = (span_limit != '0) ? span_limit : DEFAULT_WINDOW;
    gap       = (max_gap != '0) ? max_gap : DEFAULT_GAP;
    rec_start = {1'b0, record.record_offset};
    rec_end   = rec_start + END_W'(record.record_len);
    gap_limit = {1'b0, latest_start} + {1'b0, gap};
    span      = rec_end - {1'b0, open_start};
    gap_fail  = rec_start > gap_limit;
    win_fail  = (rec_end < {1'b0, open_start}) || (span > {1'b0, win});
    joins     = interval_open && !gap_fail && !win_fail;
  end

  // Next interval state
  always_comb begin
    seen_inc = records_seen + COUNT_W'(1);
    if (joins) begin
      open_start_next   = open_start;
      latest_start_next = (record.record_offset > latest_start) ?
                          record.record_offset : latest_start;
      furthest_end_next = (rec_end > furthest_end) ? rec_end : furthest_end;
      open_count_next   = open_count + COUNT_W'(1);
    end else begin
      open_start_next   = record.record_offset;
      latest_start_next = record.record_offset;
      furthest_end_next = rec_end;
      open_count_next   = COUNT_W'(1);
    end
    interval_open_next = !record.final_record;
    records_seen_next  = record.final_record ? '0 : seen_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_open <= 1'b0;
      open_start    <= '0;
      latest_start  <= '0;
      furthest_end  <= '0;
      open_count    <= '0;
      records_seen  <= '0;
    end else if (accept) begin
      interval_open <= interval_open_next;
      open_start    <= open_start_next;
      latest_start  <= latest_start_next;
      furthest_end  <= furthest_end_next;
      open_count    <= record.final_record ? '0 : open_count_next;
      records_seen  <= records_seen_next;
    end
  end

  // Result a: interval closed by a record that does not join.
  // Result b: flush at the end of the plan.
  always_comb begin
    push.valid_a = accept && interval_open && !joins;
    push.valid_b = accept && record.final_record;

    result_a.interval_offset = open_start;
    result_a.interval_size   = furthest_end - {1'b0, open_start};
    result_a.interval_tasks  = open_count;
    result_a.first_index     = records_seen - open_count;
    result_a.last_of_run     = !record.final_record;

    result_b.interval_offset = open_start_next;
    result_b.interval_size   = furthest_end_next - {1'b0, open_start_next};
    result_b.interval_tasks  = open_count_next;
    result_b.first_index     = seen_inc - open_count_next;
    result_b.last_of_run     = 1'b1;
  end

  ric_out_queue #(
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .push_a         (result_a),
    .push_b         (result_b),
    .room_for_two   (room_for_two),
    .interval_valid (interval_valid),
    .interval_ready (interval_ready),
    .interval       (interval)
  );

endmodule

/* tb/sv/read_interval_checker.sv */
module read_interval_checker import ric_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 record_valid,
  input  logic                 record_ready,
  input  ric_record_t          record,
  input  logic                 interval_valid,
  input  logic                 interval_ready,
  input  ric_interval_t        interval,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OFFSET_W-1:0]  cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the registers
  logic [OFFSET_W-1:0] span_reg;
  logic [OFFSET_W-1:0] gap_reg;

  // Shadow copy of the open interval and the plan position
  logic                iv_open;
  logic [OFFSET_W-1:0] iv_start;
  logic [OFFSET_W-1:0] iv_latest;
  logic [END_W-1:0]    iv_reach;
  logic [COUNT_W-1:0]  iv_count;
  logic [COUNT_W-1:0]  plan_pos;

  ric_interval_t expected_intervals[$];
  int            errors_seen = 0;

  assign fail_count = errors_seen;

  // Interval as it would leave the block if closed now
  function automatic ric_interval_t closed_interval();
    ric_interval_t iv;
    iv.interval_offset = iv_start;
    iv.interval_size   = iv_reach - {1'b0, iv_start};
    iv.interval_tasks  = iv_count;
    iv.first_index     = plan_pos - iv_count;
    iv.last_of_run     = 1'b0;
    return iv;
  endfunction

  // Merge one accepted record and queue the intervals it closes
  task automatic merge_record(input ric_record_t rec);
    logic [END_W-1:0]    rec_end;
    logic [END_W:0]      gap_reach;
    logic [OFFSET_W-1:0] win;
    logic [OFFSET_W-1:0] gap;
    logic                joins;
    ric_interval_t       res [2];
    int                  n;
    rec_end   = {1'b0, rec.record_offset} + {17'b0, rec.record_len};
    win       = (span_reg != '0) ? span_reg : DEFAULT_WINDOW;
    gap       = (gap_reg != '0) ? gap_reg : DEFAULT_GAP;
    gap_reach = {2'b0, iv_latest} + {2'b0, gap};
    n         = 0;
    // both tests, the window one failing when the end falls below the start
    joins = iv_open
         && ({2'b0, rec.record_offset} <= gap_reach)
         && (rec_end >= {1'b0, iv_start})
         && ((rec_end - {1'b0, iv_start}) <= {1'b0, win});
    if (joins) begin
      if (rec_end > iv_reach) iv_reach = rec_end;
      if (rec.record_offset > iv_latest) iv_latest = rec.record_offset;
      iv_count = iv_count + 1'b1;
    end else begin
      if (iv_open) begin
        res[n] = closed_interval();
        n++;
      end
      iv_open   = 1'b1;
      iv_start  = rec.record_offset;
      iv_latest = rec.record_offset;
      iv_reach  = rec_end;
      iv_count  = 1;
    end
    plan_pos = plan_pos + 1'b1;
    // end of plan flushes and restarts the position count
    if (rec.final_record) begin
      res[n] = closed_interval();
      n++;
      iv_open  = 1'b0;
      iv_count = '0;
      plan_pos = '0;
    end
    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++)
      expected_intervals.insert(expected_intervals.size(), res[i]);
  endtask

  // Compare one accepted interval with the oldest expectation
  task automatic check_interval(input ric_interval_t got);
    ric_interval_t want;
    logic          bad;
    if (expected_intervals.size() == 0) begin
      $display("%0t: unexpected interval offset %0d size %0d tasks %0d", $time,
               got.interval_offset, got.interval_size, got.interval_tasks);
      errors_seen++;
    end else begin
      want = expected_intervals.pop_front();
      bad  = 1'b0;
      if (got.interval_offset !== want.interval_offset) begin
        $display("%0t: interval_offset expected %0d got %0d", $time,
                 want.interval_offset, got.interval_offset);
        bad = 1'b1;
      end
      if (got.interval_size !== want.interval_size) begin
        $display("%0t: interval_size expected %0d got %0d", $time,
                 want.interval_size, got.interval_size);
        bad = 1'b1;
      end
      if (got.interval_tasks !== want.interval_tasks) begin
        $display("%0t: interval_tasks expected %0d got %0d", $time,
                 want.interval_tasks, got.interval_tasks);
        bad = 1'b1;
      end
      if (got.first_index !== want.first_index) begin
        $display("%0t: first_index expected %0d got %0d", $time,
                 want.first_index, got.first_index);
        bad = 1'b1;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run expected %0b got %0b", $time,
                 want.last_of_run, got.last_of_run);
        bad = 1'b1;
      end
      if (bad) errors_seen++;
    end
  endtask

  // Outputs first: an interval seen now was closed by an earlier record
  always @(posedge clk) begin
    if (rst) begin
      span_reg  = '0;
      gap_reg   = '0;
      iv_open   = 1'b0;
      iv_start  = '0;
      iv_latest = '0;
      iv_reach  = '0;
      iv_count  = '0;
      plan_pos  = '0;
      expected_intervals.delete();
      errors_seen = 0;
      pending <= 0;
    end else begin
      if (interval_valid && interval_ready) check_interval(interval);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SPAN_LIMIT) span_reg = cfg_data;
        else if (cfg_index == REG_MAX_GAP) gap_reg = cfg_data;
      end
      if (record_valid && record_ready) merge_record(record);
      pending <= expected_intervals.size();
    end
  end

endmodule

/* tb/sv/tb_read_interval_coalescer.sv */
module tb_read_interval_coalescer;
  import ric_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 240;
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = 8'hFF;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 record_valid = 1'b0;
  logic                 record_ready;
  ric_record_t          record_req = '0;
  logic                 interval_valid;
  logic                 interval_ready = 1'b0;
  ric_interval_t        interval_resp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [OFFSET_W-1:0]  cfg_data = '0;

  int fail_count;
  int pending_intervals;

  // stimulus shaping: effective limits, quiet stretch, receiver hold-offs
  logic [OFFSET_W-1:0] eff_win = DEFAULT_WINDOW;
  logic [OFFSET_W-1:0] eff_gap = DEFAULT_GAP;
  logic                calm = 1'b0;
  int                  holds_asked = 0;
  int                  holds_served = 0;
  int                  hold_left = 0;
  int                  quiet_cycles = 0;

  read_interval_coalescer dut (
    .clk            (clk),
    .rst            (rst),
    .record_valid   (record_valid),
    .record_ready   (record_ready),
    .record         (record_req),
    .interval_valid (interval_valid),
    .interval_ready (interval_ready),
    .interval       (interval_resp),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  read_interval_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .record_valid   (record_valid),
    .record_ready   (record_ready),
    .record         (record_req),
    .interval_valid (interval_valid),
    .interval_ready (interval_ready),
    .interval       (interval_resp),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending_intervals)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((record_valid && record_ready) || (interval_valid && interval_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[read_interval_coalescer] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus long hold-offs on demand
  always @(posedge clk) begin
    if (rst) begin
      interval_ready <= 1'b0;
    end else if (hold_left != 0) begin
      interval_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served < holds_asked) begin
      interval_ready <= 1'b0;
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      interval_ready <= calm || ($urandom_range(99) >= 34);
    end
  end

  function automatic logic [OFFSET_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[OFFSET_W-1:0];
  endfunction

  // Offer one record request, idling at random first
  task automatic send_record(input logic [OFFSET_W-1:0] off, input logic [SIZE_W-1:0] size,
                             input logic fin);
    while (!calm && $urandom_range(99) < 34) begin
      record_valid <= 1'b0;
      @(posedge clk);
    end
    record_valid <= 1'b1;
    record_req   <= '{record_offset: off, record_len: size, final_record: fin};
    @(posedge clk);
    while (!record_ready) @(posedge clk);
  endtask

  // Stop offering, wait out every expected interval and the block's latency
  task automatic drain_and_pause();
    record_valid <= 1'b0;
    @(posedge clk);
    while (pending_intervals != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OFFSET_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_limits(input logic [OFFSET_W-1:0] win, input logic [OFFSET_W-1:0] gap);
    drain_and_pause();
    write_reg(REG_SPAN_LIMIT, win);
    write_reg(REG_MAX_GAP, gap);
    cfg_valid <= 1'b0;
    eff_win = (win != '0) ? win : DEFAULT_WINDOW;
    eff_gap = (gap != '0) ? gap : DEFAULT_GAP;
  endtask

  // Random plans: mostly sorted records with steps around the gap limit
  // and sizes around the window, some backward steps as noise
  task automatic run_plans(input int count);
    logic [OFFSET_W-1:0] off;
    logic [OFFSET_W-1:0] step;
    logic [SIZE_W-1:0]   size;
    logic [31:0]         near_gap;
    logic [31:0]         near_win;
    int                  made;
    int                  len;
    int                  pick;
    made     = 0;
    near_gap = (eff_gap < 48'd2000) ? eff_gap[31:0] : 32'd2000;
    near_win = (eff_win < 48'd4096) ? eff_win[31:0] : 32'd4096;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 10) off = OFFSET_W'($urandom_range(4095));
      else if (pick < 20) off = ~OFFSET_W'($urandom_range(65535));
      else off = rand48();
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(8, 1);
      for (int k = 0; k < len; k++) begin
        if (k > 0) begin
          pick = $urandom_range(99);
          if (pick < 15) step = '0;
          else if (pick < 50) step = OFFSET_W'($urandom_range(near_gap));
          else if (pick < 60) step = eff_gap;
          else if (pick < 70) step = eff_gap + 1'b1;
          else if (pick < 82) step = rand48() >> $urandom_range(47, 8);
          else if (pick < 92) step = -OFFSET_W'($urandom_range(3000, 1));
          else step = eff_gap >> 1;
          off = off + step;
        end
        pick = $urandom_range(99);
        if (pick < 30) size = $urandom_range(64);
        else if (pick < 50) size = $urandom_range(near_win);
        else if (pick < 62 && eff_win <= 48'hFFFF_FFFE) size = eff_win[31:0] + $urandom_range(2) - 1;
        else if (pick < 85) size = $urandom;
        else size = $urandom_range(65535);
        send_record(off, size, k == len - 1);
        made++;
      end
    end
  endtask

  initial begin
    logic [OFFSET_W-1:0] base;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, registers at their reset value (defaults)
    // lone record that also ends its plan
    send_record(48'd0, 32'd0, 1'b1);
    // gap test at its limit, then one past it
    send_record(48'd1000, 32'd16, 1'b0);
    send_record(48'd1000 + DEFAULT_GAP, 32'd0, 1'b0);
    base = 48'd1001 + DEFAULT_GAP + DEFAULT_GAP;
    send_record(base, 32'd4, 1'b0);
    // window test at its limit, then one past it
    send_record(base + 48'd100, DEFAULT_WINDOW[31:0] - 32'd100, 1'b0);
    send_record(base + 48'd200, DEFAULT_WINDOW[31:0] - 32'd199, 1'b0);
    send_record(base + 48'd200, 32'd0, 1'b1);
    // one request both closes an interval and ends the plan
    send_record(48'h1234_5678, 32'd64, 1'b0);
    send_record(48'h1234_5678 + DEFAULT_GAP + 48'd65, 32'd5, 1'b1);
    // record ending below the interval start
    send_record(48'd5000, 32'd10, 1'b0);
    send_record(48'd4000, 32'd10, 1'b0);
    send_record(48'd4500, 32'd0, 1'b1);
    // unsorted: latest start keeps its maximum
    send_record(48'd10000, 32'd0, 1'b0);
    send_record(48'd20000, 32'd0, 1'b0);
    send_record(48'd15000, 32'd0, 1'b0);
    send_record(48'd20000 + DEFAULT_GAP, 32'd0, 1'b1);
    // extremes of offset and size
    send_record('1, '1, 1'b0);
    send_record('1, 32'd0, 1'b1);
    // oversize first record is never held against the window
    send_record(48'd0, '1, 1'b0);
    send_record(48'd1, 32'd1, 1'b1);
    // repeated offset
    send_record(48'd7, 32'd3, 1'b0);
    send_record(48'd7, 32'd3, 1'b1);

    // Zero written explicitly selects the defaults
    set_limits('0, '0);
    run_plans(90);

    // Tight limits: many closes; receiver holds off to fill the block
    set_limits(48'd1000, 48'd100);
    holds_asked <= holds_asked + 1;
    run_plans(150);

    // Writes to unmapped indexes must leave the limits alone
    drain_and_pause();
    write_reg(REG_UNMAPPED, '1);
    write_reg(REG_INDEX_TOP, '1);
    cfg_valid <= 1'b0;
    run_plans(40);

    // Widest limits, no idling on either side
    set_limits('1, '1);
    calm <= 1'b1;
    send_record(48'd0, 32'd0, 1'b0);
    send_record('1, '1, 1'b1);
    run_plans(80);
    calm <= 1'b0;

    // Narrowest limits
    set_limits(48'd1, 48'd1);
    run_plans(80);

    // Default window with a small gap, second hold-off
    set_limits('0, 48'd300);
    holds_asked <= holds_asked + 1;
    run_plans(60);

    // Small window with the default gap
    set_limits(48'd5000, '0);
    run_plans(60);

    // Window shrunk while an interval is open
    drain_and_pause();
    send_record(48'h00AB_CDEF_0000, 32'd2, 1'b0);
    drain_and_pause();
    write_reg(REG_SPAN_LIMIT, 48'd10);
    cfg_valid <= 1'b0;
    eff_win = 48'd10;
    send_record(48'h00AB_CDEF_0005, 32'd6, 1'b0);
    send_record(48'h00AB_CDEF_0005, 32'd0, 1'b1);

    // Random limits
    repeat (4) begin
      set_limits(rand48() >> $urandom_range(44, 20), rand48() >> $urandom_range(46, 24));
      run_plans(40);
    end

    drain_and_pause();
    repeat (16) @(posedge clk);
    if (fail_count == 0)
      $display("[read_interval_coalescer] OK");
    else
      $display("[read_interval_coalescer] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ric_pkg.sv
rtl/ric_out_queue.sv
rtl/read_interval_coalescer.sv
tb/sv/read_interval_checker.sv
tb/sv/tb_read_interval_coalescer.sv
